>>> rtl/core/led_blink_pattern_generator_assert.svh
// Assertion macros for the LED blink pattern generator.
// Used by the top level; needs clk and arst_n in the including scope.
`ifndef LED_BLINK_PATTERN_GENERATOR_ASSERT_SVH
`define LED_BLINK_PATTERN_GENERATOR_ASSERT_SVH

// check a property every clock edge outside reset
`define LBPG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check that a condition implies a property at the same edge
`define LBPG_ASSERT_IMPLY(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// check that a condition implies a property at the next edge
`define LBPG_ASSERT_NEXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

>>> rtl/core/lbpg_pkg.sv
// Shared types, constants and helper functions of the LED blink pattern generator.
// No dependencies.
package lbpg_pkg;

	localparam int TIME_W = 32;
	localparam int REM_W  = 16;
	localparam int CNT_W  = $clog2(TIME_W);
	localparam int ELAP_W = 9;

	localparam logic [REM_W-1:0]  PREVIEW_DEFAULT_MS = 16'd800;
	localparam logic [REM_W-1:0]  PULSE_ON_MS        = 16'd120;
	localparam logic [REM_W-1:0]  PULSE_GAP_MS       = 16'd80;
	localparam logic [REM_W-1:0]  PULSE_STEP_MS      = PULSE_ON_MS + PULSE_GAP_MS;
	localparam logic [ELAP_W-1:0] CONFIRM_LIMIT_MS   = 9'd400;
	localparam logic [ELAP_W-1:0] ELAPSED_SAT        = 9'd401;
	localparam logic [7:0]        FULL               = 8'd255;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_SET  = 1'b1;

	typedef enum logic [1:0] {
		CFG_PERIOD      = 2'd0,
		CFG_ACTIVE_HIGH = 2'd1,
		CFG_IS_RGB      = 2'd2,
		CFG_PIN_PRESENT = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		MODE_OFF       = 3'd0,
		MODE_ON        = 3'd1,
		MODE_PV_SHORT  = 3'd2,
		MODE_PV_LONG   = 3'd3,
		MODE_PV_VLONG  = 3'd4,
		MODE_CF_SHORT  = 3'd5,
		MODE_CF_LONG   = 3'd6,
		MODE_CF_VLONG  = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic       op;
		logic [2:0] new_mode;
	} in_item_t;

	typedef struct packed {
		logic       pin_write;
		logic       pin_level;
		logic       colour_write;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [2:0] mode_now;
	} out_item_t;

	typedef struct packed {
		logic [REM_W-1:0] period_ms;
		logic             active_high;
		logic             is_rgb;
		logic             pin_present;
	} cfg_t;

	typedef struct packed {
		logic             done;
		logic [REM_W-1:0] rem;
	} rem_sts_t;

	function automatic logic [1:0] pulse_count(mode_t m);
		logic [1:0] n;
		unique case (m) inside
			MODE_PV_SHORT, MODE_CF_SHORT: n = 2'd1;
			MODE_PV_LONG, MODE_CF_LONG:   n = 2'd2;
			MODE_PV_VLONG, MODE_CF_VLONG: n = 2'd3;
			default:                      n = 2'd0;
		endcase
		return n;
	endfunction

	// one full toggle sequence of a confirm mode: 2n slots of PULSE_ON_MS
	function automatic logic [REM_W-1:0] confirm_span(mode_t m);
		logic [REM_W-1:0] s;
		unique case (pulse_count(m))
			2'd1:    s = REM_W'(2 * PULSE_ON_MS);
			2'd2:    s = REM_W'(4 * PULSE_ON_MS);
			2'd3:    s = REM_W'(6 * PULSE_ON_MS);
			default: s = PREVIEW_DEFAULT_MS;
		endcase
		return s;
	endfunction

endpackage

>>> rtl/core/led_blink_pattern_generator.sv
// LED blink pattern generator top level: sequencer, state, settings, output register.
// Depends on lbpg_pkg, lbpg_rem_unit, lbpg_eval and the assertion macro header.
//
//  channel | direction | handshake            | payload
//  in      | to block  | in_valid / in_ready  | in_data (in_item_t)
//  out     | from block| out_valid / out_ready| out_data (out_item_t)
//  cfg     | to block  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// When the result is taken at once, an item passes in order through acceptance, the
// remainder unit (one bit of the time counter per cycle), loading of the result
// register and transfer. A new item is accepted only once the last one is sent.
// Reset puts the block in idle, mode off, time and elapsed timer at zero.
// A stalled result holds the block; cfg_ready is always high.
`include "led_blink_pattern_generator_assert.svh"

module led_blink_pattern_generator
	import lbpg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  cfg_idx_t   cfg_index,
	input  logic [15:0] cfg_data
);

	state_t            state_q;
	state_t            state_d;
	cfg_t              cfg_q;
	mode_t             mode_q;
	mode_t             mode_in;
	logic [TIME_W-1:0] time_q;
	logic [TIME_W-1:0] time_d;
	logic [ELAP_W-1:0] elapsed_q;
	out_item_t         out_q;
	out_item_t         res;
	rem_sts_t          rem_sts;
	logic              start;
	logic [REM_W-1:0]  divisor;
	logic [REM_W-1:0]  period;

	assign cfg_ready = 1'b1;
	assign mode_in   = (in_data.op == OP_SET) ? mode_t'(in_data.new_mode) : mode_q;
	assign time_d    = (in_data.op == OP_TICK) ? time_q + 1'b1 : time_q;
	assign period    = (cfg_q.period_ms == '0) ? PREVIEW_DEFAULT_MS : cfg_q.period_ms;
	assign divisor   = (mode_in >= MODE_CF_SHORT) ? confirm_span(mode_in) : period;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		start     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					start   = 1'b1;
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (rem_sts.done) begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period_ms   <= '0;
			cfg_q.active_high <= 1'b1;
			cfg_q.is_rgb      <= 1'b0;
			cfg_q.pin_present <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_PERIOD:      cfg_q.period_ms   <= cfg_data;
				CFG_ACTIVE_HIGH: cfg_q.active_high <= cfg_data[0];
				CFG_IS_RGB:      cfg_q.is_rgb      <= cfg_data[0];
				CFG_PIN_PRESENT: cfg_q.pin_present <= cfg_data[0];
				default:         cfg_q.period_ms   <= cfg_q.period_ms;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_OFF;
			time_q    <= '0;
			elapsed_q <= '0;
		end else if (start) begin
			mode_q <= mode_in;
			time_q <= time_d;
			if (in_data.op == OP_SET) begin
				elapsed_q <= '0;
			end else if (elapsed_q < ELAPSED_SAT) begin
				elapsed_q <= elapsed_q + 1'b1;
			end
		end else if (state_q == ST_RUN && rem_sts.done) begin
			mode_q <= mode_t'(res.mode_now);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RUN && rem_sts.done) begin
			out_q <= res;
		end
	end

	assign out_data = out_q;

	lbpg_rem_unit u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.dividend (time_d),
		.divisor  (divisor),
		.sts      (rem_sts)
	);

	lbpg_eval u_eval (
		.mode    (mode_q),
		.elapsed (elapsed_q),
		.rem     (rem_sts.rem),
		.cfg     (cfg_q),
		.res     (res)
	);

	`LBPG_ASSERT(a_no_overlap, !(in_ready && out_valid), "input and output open together")
	`LBPG_ASSERT_IMPLY(a_done_in_run, rem_sts.done, state_q == ST_RUN, "remainder done outside run")
	`LBPG_ASSERT_NEXT(a_accept_runs, in_valid && in_ready, state_q == ST_RUN, "accept did not start run")
	`LBPG_ASSERT(a_elapsed_sat, elapsed_q <= ELAPSED_SAT, "elapsed timer past saturation")

endmodule

>>> rtl/core/lbpg_rem_unit.sv
// Bit-serial restoring remainder unit: 32-bit dividend by 16-bit divisor.
// One dividend bit per cycle. Depends on lbpg_pkg.
module lbpg_rem_unit
	import lbpg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [TIME_W-1:0] dividend,
	input  logic [REM_W-1:0]  divisor,
	output rem_sts_t          sts
);

	logic              run_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [TIME_W-1:0] dvd_q;
	logic [REM_W-1:0]  div_q;
	logic [REM_W-1:0]  rem_q;
	logic [REM_W:0]    shifted;
	logic [REM_W:0]    diff;

	assign shifted = {rem_q, dvd_q[TIME_W-1]};
	assign diff    = shifted - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(TIME_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[TIME_W-2:0], 1'b0};
			if (!diff[REM_W]) begin
				rem_q <= diff[REM_W-1:0];
			end else begin
				rem_q <= shifted[REM_W-1:0];
			end
		end
	end

	assign sts.done = done_q;
	assign sts.rem  = rem_q;

endmodule

>>> rtl/core/lbpg_eval.sv
// Pattern evaluation: turns mode, remainder and settings into one result item.
// Depends on lbpg_pkg.
module lbpg_eval
	import lbpg_pkg::*;
(
	input  mode_t             mode,
	input  logic [ELAP_W-1:0] elapsed,
	input  logic [REM_W-1:0]  rem,
	input  cfg_t              cfg,
	output out_item_t         res
);

	logic       lit;
	logic       mono;
	logic       colour;
	logic [1:0] n;
	mode_t      mode_next;

	always_comb begin
		n         = pulse_count(mode);
		lit       = 1'b0;
		mono      = 1'b0;
		colour    = 1'b0;
		mode_next = mode;
		res       = '0;
		unique case (mode) inside
			MODE_OFF, MODE_ON: begin
				lit  = (mode == MODE_ON);
				mono = 1'b1;
				if (cfg.is_rgb) begin
					res.colour_write = 1'b1;
					res.red          = lit ? FULL : 8'd0;
					res.green        = lit ? FULL : 8'd0;
					res.blue         = lit ? FULL : 8'd0;
				end
			end
			MODE_PV_SHORT, MODE_PV_LONG, MODE_PV_VLONG: begin
				colour = cfg.is_rgb;
				mono   = !cfg.is_rgb;
				lit    = (rem < PULSE_ON_MS)
					|| (n >= 2'd2 && rem >= PULSE_STEP_MS
						&& rem < PULSE_STEP_MS + PULSE_ON_MS)
					|| (n == 2'd3 && rem >= REM_W'(2 * PULSE_STEP_MS)
						&& rem < REM_W'(2 * PULSE_STEP_MS + PULSE_ON_MS));
			end
			default: begin
				colour = cfg.is_rgb;
				mono   = !cfg.is_rgb;
				// lit on even slots of PULSE_ON_MS
				lit    = !((rem >= PULSE_ON_MS && rem < REM_W'(2 * PULSE_ON_MS))
					|| (rem >= REM_W'(3 * PULSE_ON_MS) && rem < REM_W'(4 * PULSE_ON_MS))
					|| (rem >= REM_W'(5 * PULSE_ON_MS) && rem < REM_W'(6 * PULSE_ON_MS)));
				if (elapsed > CONFIRM_LIMIT_MS) begin
					mode_next = MODE_OFF;
				end
			end
		endcase
		if (colour) begin
			res.colour_write = 1'b1;
			unique case (n)
				2'd1: begin
					res.red   = FULL;
					res.green = FULL;
					res.blue  = FULL;
				end
				2'd2: begin
					res.red   = 8'd0;
					res.green = FULL;
					res.blue  = FULL;
				end
				default: begin
					res.red   = FULL;
					res.green = 8'd0;
					res.blue  = 8'd0;
				end
			endcase
		end
		if (mono && cfg.pin_present) begin
			res.pin_write = 1'b1;
			res.pin_level = (lit == cfg.active_high);
		end
		res.mode_now = mode_next;
	end

endmodule
